/* hw/rtl/drrs_pkg.sv */
// ----------------------------------------------------------------------------
// drrs_pkg
// Shared constants, result kind codes and controller/datapath interface
// structs for the disc read request scheduler.
// ----------------------------------------------------------------------------
package drrs_pkg;

    // Queue sizing
    localparam int QUEUE_DEPTH = 2;
    localparam int TAG_BITS    = 8;
    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Transfer geometry
    localparam logic [15:0] BOUNDARY_BYTES = 16'd32768;
    localparam logic [16:0] SECTOR_BYTES   = 17'd512;

    // Input operations
    localparam logic OP_SUBMIT   = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_ACCEPT = 3'd0;
    localparam logic [2:0] KIND_FULL   = 3'd1;
    localparam logic [2:0] KIND_SETSEC = 3'd2;
    localparam logic [2:0] KIND_READ   = 3'd3;
    localparam logic [2:0] KIND_SEEK   = 3'd4;
    localparam logic [2:0] KIND_DONE   = 3'd5;
    localparam logic [2:0] KIND_IDLE   = 3'd6;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // latch the input transaction
        logic submit;      // queue request, emit accept or reject
        logic complete;    // emit completion or idle, free active slot
        logic set_sector;  // emit set-base-sector command
        logic issue;       // emit read or seek command, mark active
    } drrs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;      // output register can take a result this cycle
        logic is_complete;   // latched op is a completion
        logic full;          // no free slot
        logic active;        // a request is running
        logic waiting;       // a slot other than the active one is busy
        logic base_differs;  // picked sector differs from the base sector
    } drrs_status_t;

endpackage

/* hw/rtl/drrs_ctrl.sv */
// ----------------------------------------------------------------------------
// drrs_ctrl
// Sequencer for the request scheduler: takes one input transaction at a time
// and steps the datapath through the results it causes.
// ----------------------------------------------------------------------------
module drrs_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  drrs_pkg::drrs_status_t status,
    output drrs_pkg::drrs_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUBMIT,
        ST_COMPL,
        ST_START,
        ST_CMD
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SUBMIT;
                end
            end
            ST_SUBMIT:
            begin
                // latched op decides which path is taken
                if (status.is_complete)
                begin
                    state_next = ST_COMPL;
                end
                else if (status.out_free)
                begin
                    cmd.submit = 1'b1;
                    state_next = (status.full || status.active) ? ST_IDLE : ST_START;
                end
            end
            ST_COMPL:
            begin
                if (status.out_free)
                begin
                    cmd.complete = 1'b1;
                    state_next   = (status.active && status.waiting) ? ST_START : ST_IDLE;
                end
            end
            ST_START:
            begin
                if (status.out_free)
                begin
                    if (status.base_differs)
                    begin
                        cmd.set_sector = 1'b1;
                        state_next     = ST_CMD;
                    end
                    else
                    begin
                        cmd.issue  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CMD:
            begin
                if (status.out_free)
                begin
                    cmd.issue  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/drrs_datapath.sv */
// ----------------------------------------------------------------------------
// drrs_datapath
// Request slots, length clamp, slot selection, base sector and the result
// output register of the request scheduler.
// ----------------------------------------------------------------------------
module drrs_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  drrs_pkg::drrs_cmd_t    cmd,
    output drrs_pkg::drrs_status_t status,
    input  logic                   op,
    input  logic [31:0]            req_length,
    input  logic [31:0]            req_offset,
    input  logic [31:0]            req_sector,
    input  logic [31:0]            req_buffer,
    input  logic [7:0]             req_tag,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             kind,
    output logic [31:0]            cmd_sector,
    output logic [29:0]            word_offset,
    output logic [15:0]            xfer_length,
    output logic [31:0]            dest_addr,
    output logic [7:0]             owner_tag,
    output logic                   last
);

    localparam int DEPTH = drrs_pkg::QUEUE_DEPTH;
    localparam int SW    = drrs_pkg::SLOT_W;
    localparam int TW    = drrs_pkg::TAG_BITS;

    // Latched input transaction
    logic        op_reg;
    logic [31:0] len_reg;
    logic [31:0] off_reg;
    logic [31:0] sec_reg;
    logic [31:0] buf_reg;
    logic [7:0]  tag_reg;

    // Slot storage
    logic [DEPTH-1:0] slot_valid_reg;
    logic [DEPTH-1:0] slot_fit_reg;
    logic [15:0]      slot_length_reg [DEPTH];
    logic [31:0]      slot_offset_reg [DEPTH];
    logic [31:0]      slot_sector_reg [DEPTH];
    logic [31:0]      slot_buffer_reg [DEPTH];
    logic [TW-1:0]    slot_owner_reg  [DEPTH];

    logic          active_valid_reg;
    logic [SW-1:0] active_slot_reg;
    logic [SW-1:0] pick_reg;
    logic [31:0]   base_reg;
    logic          out_valid_reg;

    // Result register
    logic [2:0]  kind_reg;
    logic [31:0] cmd_sector_reg;
    logic [29:0] word_offset_reg;
    logic [15:0] xfer_length_reg;
    logic [31:0] dest_addr_reg;
    logic [7:0]  owner_tag_reg;
    logic        last_reg;
    logic [2:0]  kind_next;
    logic [31:0] cmd_sector_next;
    logic [29:0] word_offset_next;
    logic [15:0] xfer_length_next;
    logic [31:0] dest_addr_next;
    logic [7:0]  owner_tag_next;
    logic        last_next;

    logic [31:0]      rounded;
    logic [15:0]      limit;
    logic [15:0]      clamped;
    logic             fit;
    logic             full;
    logic [SW-1:0]    free_idx;
    logic [DEPTH-1:0] others;
    logic [SW-1:0]    next_idx;
    logic             next_fit_found;
    logic             next_any_found;
    logic [SW-1:0]    next_fit_idx;
    logic [SW-1:0]    next_any_idx;
    logic [SW-1:0]    rd_idx;
    logic             emit;

    // Length clamp at the 32-byte-rounded offset boundary
    always_comb
    begin
        rounded = (off_reg + 32'd31) & ~32'd31;
        limit   = drrs_pkg::BOUNDARY_BYTES - {1'b0, rounded[14:0]};
        clamped = (len_reg > {16'd0, limit}) ? limit : len_reg[15:0];
        fit     = ({1'b0, clamped} + {8'd0, off_reg[8:0]}) <= drrs_pkg::SECTOR_BYTES;
    end

    // Lowest free slot
    always_comb
    begin
        full     = 1'b1;
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                full     = 1'b0;
                free_idx = SW'(i);
            end
        end
    end

    // Next request after the active one: lowest sector-fitting, else lowest
    always_comb
    begin
        others         = slot_valid_reg;
        others[active_slot_reg] = 1'b0;
        next_fit_found = 1'b0;
        next_any_found = 1'b0;
        next_fit_idx   = '0;
        next_any_idx   = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (others[i])
            begin
                next_any_found = 1'b1;
                next_any_idx   = SW'(i);
                if (slot_fit_reg[i])
                begin
                    next_fit_found = 1'b1;
                    next_fit_idx   = SW'(i);
                end
            end
        end
        next_idx = next_fit_found ? next_fit_idx : next_any_idx;
    end

    // Single slot read port: active slot while running, else picked slot
    assign rd_idx = active_valid_reg ? active_slot_reg : pick_reg;

    assign emit = cmd.submit | cmd.complete | cmd.set_sector | cmd.issue;

    always_comb
    begin
        status              = '0;
        status.out_free     = !out_valid_reg || !out_stall;
        status.is_complete  = (op_reg == drrs_pkg::OP_COMPLETE);
        status.full         = full;
        status.active       = active_valid_reg;
        status.waiting      = next_any_found;
        status.base_differs = (base_reg != slot_sector_reg[rd_idx]);
    end

    // Input latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            len_reg <= req_length;
            off_reg <= req_offset;
            sec_reg <= req_sector;
            buf_reg <= req_buffer;
            tag_reg <= req_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= drrs_pkg::OP_SUBMIT;
        end
        else if (cmd.capture)
        begin
            op_reg <= op;
        end
    end

    // Slot payload writes
    always_ff @(posedge clk)
    begin
        if (cmd.submit && !full)
        begin
            slot_length_reg[free_idx] <= clamped;
            slot_offset_reg[free_idx] <= off_reg;
            slot_sector_reg[free_idx] <= sec_reg;
            slot_buffer_reg[free_idx] <= buf_reg;
            slot_owner_reg[free_idx]  <= TW'(tag_reg);
        end
    end

    // Scheduler control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg   <= '0;
            slot_fit_reg     <= '0;
            active_valid_reg <= 1'b0;
            active_slot_reg  <= '0;
            pick_reg         <= '0;
            base_reg         <= '1;
        end
        else
        begin
            if (cmd.submit && !full)
            begin
                slot_valid_reg[free_idx] <= 1'b1;
                slot_fit_reg[free_idx]   <= fit;
                pick_reg                 <= free_idx;
            end
            if (cmd.complete && active_valid_reg)
            begin
                slot_valid_reg[active_slot_reg] <= 1'b0;
                active_valid_reg                <= 1'b0;
                pick_reg                        <= next_idx;
            end
            if (cmd.set_sector)
            begin
                base_reg <= slot_sector_reg[rd_idx];
            end
            if (cmd.issue)
            begin
                active_valid_reg <= 1'b1;
                active_slot_reg  <= pick_reg;
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result fields for the command in this cycle
    always_comb
    begin
        kind_next        = drrs_pkg::KIND_IDLE;
        cmd_sector_next  = '0;
        word_offset_next = '0;
        xfer_length_next = '0;
        dest_addr_next   = '0;
        owner_tag_next   = '0;
        last_next        = 1'b1;
        priority if (cmd.submit)
        begin
            if (full)
            begin
                kind_next = drrs_pkg::KIND_FULL;
            end
            else
            begin
                kind_next        = drrs_pkg::KIND_ACCEPT;
                xfer_length_next = clamped;
                last_next        = active_valid_reg;
            end
        end
        else if (cmd.complete)
        begin
            if (active_valid_reg)
            begin
                kind_next        = drrs_pkg::KIND_DONE;
                xfer_length_next = slot_length_reg[rd_idx];
                dest_addr_next   = slot_buffer_reg[rd_idx];
                owner_tag_next   = 8'(slot_owner_reg[rd_idx]);
                last_next        = !next_any_found;
            end
        end
        else if (cmd.set_sector)
        begin
            kind_next       = drrs_pkg::KIND_SETSEC;
            cmd_sector_next = slot_sector_reg[rd_idx];
            last_next       = 1'b0;
        end
        else
        begin
            word_offset_next = slot_offset_reg[rd_idx][31:2];
            if (slot_length_reg[rd_idx] != 16'd0)
            begin
                kind_next        = drrs_pkg::KIND_READ;
                xfer_length_next = slot_length_reg[rd_idx];
                dest_addr_next   = slot_buffer_reg[rd_idx];
            end
            else
            begin
                kind_next = drrs_pkg::KIND_SEEK;
            end
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg        <= kind_next;
            cmd_sector_reg  <= cmd_sector_next;
            word_offset_reg <= word_offset_next;
            xfer_length_reg <= xfer_length_next;
            dest_addr_reg   <= dest_addr_next;
            owner_tag_reg   <= owner_tag_next;
            last_reg        <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign cmd_sector  = cmd_sector_reg;
    assign word_offset = word_offset_reg;
    assign xfer_length = xfer_length_reg;
    assign dest_addr   = dest_addr_reg;
    assign owner_tag   = owner_tag_reg;
    assign last        = last_reg;

endmodule

/* hw/rtl/disc_read_request_scheduler.sv */
// ----------------------------------------------------------------------------
// disc_read_request_scheduler
// Two-slot disc read request queue: clamps, queues and starts requests and
// reports completions as a sequence of command and status results.
// Each input is latched, then the sequencer steps the datapath through up to
// three results, one per sequencer step into the output register; a completion
// first passes the ST_COMPL state. A new input is taken only once the sequencer
// is idle again, and any output stall holds the sequencer and so the input.
// Reset: queue empty, nothing active, base sector all ones.
// ----------------------------------------------------------------------------
module disc_read_request_scheduler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] req_length,
    input  logic [31:0] req_offset,
    input  logic [31:0] req_sector,
    input  logic [31:0] req_buffer,
    input  logic [7:0]  req_tag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [31:0] cmd_sector,
    output logic [29:0] word_offset,
    output logic [15:0] xfer_length,
    output logic [31:0] dest_addr,
    output logic [7:0]  owner_tag,
    output logic        last
);

    drrs_pkg::drrs_cmd_t    cmd;
    drrs_pkg::drrs_status_t status;

    // Sequencer
    drrs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Slots and result register
    drrs_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .op          (op),
        .req_length  (req_length),
        .req_offset  (req_offset),
        .req_sector  (req_sector),
        .req_buffer  (req_buffer),
        .req_tag     (req_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .cmd_sector  (cmd_sector),
        .word_offset (word_offset),
        .xfer_length (xfer_length),
        .dest_addr   (dest_addr),
        .owner_tag   (owner_tag),
        .last        (last)
    );

`ifndef NO_ASSERTIONS
    // One transaction at a time: an accepted input blocks the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted back to back");

    // A set-sector command is always followed by a read or seek
    a_setsec_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == drrs_pkg::KIND_SETSEC) |-> !last)
        else $error("set-sector result marked last");

    // Reject and idle results end their transaction
    a_single_results_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == drrs_pkg::KIND_FULL || kind == drrs_pkg::KIND_IDLE))
        |-> last)
        else $error("reject or idle result not last");

    // Only defined result kinds appear
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind <= drrs_pkg::KIND_IDLE))
        else $error("undefined result kind");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the disc read request scheduler. Submit and
// completion transactions go in through a valid/stall channel; an internal
// predictor of the two-slot queue works out the command and status results,
// and every result that leaves the block is compared field by field.
// ----------------------------------------------------------------------------
module tb;

    // One input transaction and one output result as the bench sees them
    typedef struct packed {
        logic        op;
        logic [31:0] length;
        logic [31:0] offset;
        logic [31:0] sector;
        logic [31:0] buffer;
        logic [7:0]  tag;
    } disc_req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] sector;
        logic [29:0] woff;
        logic [15:0] len;
        logic [31:0] addr;
        logic [7:0]  tag;
        logic        last;
    } disc_result_t;

    localparam int RANDOM_ITEMS = 290;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [31:0] req_length;
    logic [31:0] req_offset;
    logic [31:0] req_sector;
    logic [31:0] req_buffer;
    logic [7:0]  req_tag;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [31:0] cmd_sector;
    logic [29:0] word_offset;
    logic [15:0] xfer_length;
    logic [31:0] dest_addr;
    logic [7:0]  owner_tag;
    logic        last;

    disc_read_request_scheduler DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .req_length  (req_length),
        .req_offset  (req_offset),
        .req_sector  (req_sector),
        .req_buffer  (req_buffer),
        .req_tag     (req_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .cmd_sector  (cmd_sector),
        .word_offset (word_offset),
        .xfer_length (xfer_length),
        .dest_addr   (dest_addr),
        .owner_tag   (owner_tag),
        .last        (last)
    );

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit, far above the slowest legal run
    initial
    begin
        #5_000_000;
        $display("disc_read_request_scheduler verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predicted queue state
    // ------------------------------------------------------------------
    logic        slot_busy [drrs_pkg::QUEUE_DEPTH] = '{default: 1'b0};
    logic [15:0] slot_len  [drrs_pkg::QUEUE_DEPTH];
    logic [31:0] slot_off  [drrs_pkg::QUEUE_DEPTH];
    logic [31:0] slot_sec  [drrs_pkg::QUEUE_DEPTH];
    logic [31:0] slot_buf  [drrs_pkg::QUEUE_DEPTH];
    logic [7:0]  slot_tag  [drrs_pkg::QUEUE_DEPTH];
    logic        running     = 1'b0;
    int          running_idx = 0;
    logic [31:0] pred_base   = '1;

    disc_result_t pending_results[$];
    disc_result_t next_want;

    int error_count    = 0;
    int items_sent     = 0;
    int submits_sent   = 0;
    int results_seen   = 0;
    int full_rejects   = 0;
    int idle_completes = 0;
    int sector_cmds    = 0;
    bit calm           = 1'b0;
    int stall_left     = 0;

    function automatic void push_result(logic [2:0] k, logic [31:0] sec, logic [29:0] woff,
                                        logic [15:0] len, logic [31:0] addr, logic [7:0] tag);
        disc_result_t r;
        r = '{kind: k, sector: sec, woff: woff, len: len, addr: addr, tag: tag, last: 1'b0};
        pending_results.push_back(r);
    endfunction

    // Launch a queued request: optional base sector change, then read or seek
    function automatic void start_request(int s);
        running     = 1'b1;
        running_idx = s;
        if (pred_base != slot_sec[s])
        begin
            push_result(drrs_pkg::KIND_SETSEC, slot_sec[s], '0, '0, '0, '0);
            pred_base = slot_sec[s];
            sector_cmds++;
        end
        if (slot_len[s] != 16'd0)
            push_result(drrs_pkg::KIND_READ, '0, slot_off[s][31:2], slot_len[s],
                        slot_buf[s], '0);
        else
            push_result(drrs_pkg::KIND_SEEK, '0, slot_off[s][31:2], '0, '0, '0);
    endfunction

    // Expected results of one accepted transaction
    function automatic void schedule_step(disc_req_t req);
        logic [31:0]  rounded;
        logic [31:0]  limit;
        logic [31:0]  len;
        bit           placed;
        bit           started;
        disc_result_t tail;
        placed  = 1'b0;
        started = 1'b0;
        if (req.op == drrs_pkg::OP_SUBMIT)
        begin
            // keep the transfer inside one 32 KiB window of the rounded offset
            rounded = (req.offset + 32'd31) & ~32'd31;
            limit   = 32'(drrs_pkg::BOUNDARY_BYTES) - {17'd0, rounded[14:0]};
            len     = (req.length > limit) ? limit : req.length;
            for (int i = 0; i < drrs_pkg::QUEUE_DEPTH; i++)
            begin
                if (!placed && !slot_busy[i])
                begin
                    placed       = 1'b1;
                    slot_busy[i] = 1'b1;
                    slot_len[i]  = len[15:0];
                    slot_off[i]  = req.offset;
                    slot_sec[i]  = req.sector;
                    slot_buf[i]  = req.buffer;
                    slot_tag[i]  = req.tag;
                    push_result(drrs_pkg::KIND_ACCEPT, '0, '0, len[15:0], '0, '0);
                    if (!running)
                        start_request(i);
                end
            end
            if (!placed)
            begin
                push_result(drrs_pkg::KIND_FULL, '0, '0, '0, '0, '0);
                full_rejects++;
            end
        end
        else if (!running)
        begin
            push_result(drrs_pkg::KIND_IDLE, '0, '0, '0, '0, '0);
            idle_completes++;
        end
        else
        begin
            push_result(drrs_pkg::KIND_DONE, '0, '0, slot_len[running_idx],
                        slot_buf[running_idx], slot_tag[running_idx]);
            slot_busy[running_idx] = 1'b0;
            running = 1'b0;
            // prefer a waiting request that fits in one sector
            for (int i = 0; i < drrs_pkg::QUEUE_DEPTH; i++)
            begin
                if (!started && slot_busy[i] &&
                    ({16'd0, slot_len[i]} + {23'd0, slot_off[i][8:0]})
                    <= 32'(drrs_pkg::SECTOR_BYTES))
                begin
                    start_request(i);
                    started = 1'b1;
                end
            end
            for (int i = 0; i < drrs_pkg::QUEUE_DEPTH; i++)
            begin
                if (!started && slot_busy[i])
                begin
                    start_request(i);
                    started = 1'b1;
                end
            end
        end
        tail = pending_results.pop_back();
        tail.last = 1'b1;
        pending_results.push_back(tail);
    endfunction

    // ------------------------------------------------------------------
    // Idle lengths: mostly none or short, a few long, none in calm stretches
    // ------------------------------------------------------------------
    function automatic int pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Send one transaction and predict its results on acceptance
    task automatic send_item(input disc_req_t req);
        int gap;
        gap = pick_delay();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= req.op;
        req_length <= req.length;
        req_offset <= req.offset;
        req_sector <= req.sector;
        req_buffer <= req.buffer;
        req_tag    <= req.tag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        schedule_step(req);
        items_sent++;
        if (req.op == drrs_pkg::OP_SUBMIT)
            submits_sent++;
        if ($urandom_range(0, 29) == 0)
            calm = !calm;
    endtask

    function automatic disc_req_t submit_req(logic [31:0] len, logic [31:0] off,
                                             logic [31:0] sec, logic [31:0] buff,
                                             logic [7:0] tag);
        return '{op: drrs_pkg::OP_SUBMIT, length: len, offset: off, sector: sec,
                 buffer: buff, tag: tag};
    endfunction

    task automatic send_complete();
        disc_req_t req;
        req = '{op: drrs_pkg::OP_COMPLETE, length: $urandom, offset: $urandom,
                sector: $urandom, buffer: $urandom, tag: 8'($urandom)};
        send_item(req);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall and result check
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            stall_left <= pick_delay();
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH result %0d %s: got %0h expected %0h at %0t",
                 results_seen, what, got, want, $time);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, kind", 32'(kind), '0);
            else
            begin
                next_want = pending_results.pop_front();
                check_field("kind",        32'(kind),        32'(next_want.kind));
                check_field("cmd_sector",  cmd_sector,       next_want.sector);
                check_field("word_offset", 32'(word_offset), 32'(next_want.woff));
                check_field("xfer_length", 32'(xfer_length), 32'(next_want.len));
                check_field("dest_addr",   dest_addr,        next_want.addr);
                check_field("owner_tag",   32'(owner_tag),   32'(next_want.tag));
                check_field("last",        32'(last),        32'(next_want.last));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Completion event with nothing running
    task automatic test_idle_completion();
        send_complete();
    endtask

    // Seek with unchanged base, queue full, start of a waiting request
    task automatic test_queue_and_start();
        send_item(submit_req(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 8'h00));
        // offset rounding wraps to zero, length clamps to a full window
        send_item(submit_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 8'hFF));
        send_item(submit_req(32'd5, 32'd64, 32'd7, 32'h0000_1234, 8'h03));
        send_complete();
        send_complete();
        send_complete();
    endtask

    // Length clamping at the 32 KiB window edge
    task automatic test_clamping();
        send_item(submit_req(32'd1000, 32'h0000_7FC0, 32'd0, 32'hA5A5_0000, 8'h5A));
        send_item(submit_req(32'h0000_8000, 32'h0000_7FE1, 32'd9, 32'h5A5A_FFFC, 8'hA5));
        send_complete();
        send_complete();
        send_item(submit_req(32'd33, 32'h0000_0010, 32'd9, 32'h0000_0040, 8'h01));
        send_item(submit_req(32'd32737, 32'h0000_0020, 32'd9, 32'h0000_0080, 8'h80));
        send_complete();
        send_complete();
    endtask

    // Completion starts the one waiting request, sector-fitting or not
    task automatic test_completion_pick();
        send_item(submit_req(32'd600, 32'd0, 32'd11, 32'h1000_0000, 8'h11));
        send_item(submit_req(32'd512, 32'd0, 32'd11, 32'h2000_0000, 8'h22));
        send_complete();
        send_item(submit_req(32'd513, 32'h0000_0200, 32'd12, 32'h3000_0000, 8'h33));
        send_complete();
        send_complete();
    endtask

    // Mixed traffic with field values aimed at the interesting corners
    task automatic test_random_traffic();
        disc_req_t req;
        int        r;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) < 45)
                send_complete();
            else
            begin
                req.op = drrs_pkg::OP_SUBMIT;
                r = $urandom_range(0, 9);
                if (r == 0)
                    req.length = 32'd0;
                else if (r < 4)
                    req.length = $urandom_range(1, 512);
                else if (r < 6)
                    req.length = $urandom_range(513, 40000);
                else if (r == 6)
                    req.length = 32'd512;
                else
                    req.length = $urandom;
                r = $urandom_range(0, 8);
                if (r < 4)
                    req.offset = $urandom;
                else if (r < 6)
                    req.offset = $urandom_range(0, 1023);
                else if (r < 8)
                    req.offset = {17'($urandom), 15'h7FE0} + 32'($urandom_range(0, 31));
                else
                    req.offset = 32'hFFFF_FFE0 + 32'($urandom_range(0, 31));
                r = $urandom_range(0, 9);
                if (r < 6)
                    req.sector = $urandom_range(0, 3);
                else if (r == 6)
                    req.sector = '1;
                else
                    req.sector = $urandom;
                req.buffer = $urandom;
                req.tag    = 8'($urandom);
                send_item(req);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        op         <= drrs_pkg::OP_SUBMIT;
        req_length <= '0;
        req_offset <= '0;
        req_sector <= '0;
        req_buffer <= '0;
        req_tag    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_completion();
        test_queue_and_start();
        test_clamping();
        test_completion_pick();
        test_random_traffic();
        in_valid <= 1'b0;

        // drain, then leave room for anything stray
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d transactions (%0d submits), checked %0d results",
                 items_sent, submits_sent, results_seen);
        $display("Saw %0d full rejects, %0d idle completions, %0d base sector changes",
                 full_rejects, idle_completes, sector_cmds);
        if (error_count == 0)
            $display("disc_read_request_scheduler verification clean");
        else
            $display("disc_read_request_scheduler verification failed");
        $finish;
    end

endmodule
